/* sv/gpio_bank_pkg.sv */
`default_nettype none

package gpio_bank_pkg;

   // Port widths are fixed; the pin count only trims internal storage
   localparam int unsigned WORD_BITS = 32;

   // Command carried by a request word
   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_READ   = 2'd1,
      OP_WRITE  = 2'd2
   } opcode_type;

   // Register map
   typedef enum logic [2:0] {
      REG_OUT        = 3'd0,
      REG_IN         = 3'd1,
      REG_STATUS     = 3'd2,
      REG_CLEAR      = 3'd3,
      REG_ENABLE     = 3'd4,
      REG_EDGE       = 3'd5,
      REG_POLARITY   = 3'd6,
      REG_OUT_ENABLE = 3'd7
   } reg_select_type;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [2:0]           reg_select;
      logic [WORD_BITS-1:0] write_data;
      logic [WORD_BITS-1:0] pin_levels;
   } req_word_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] read_data;
      logic [WORD_BITS-1:0] pin_drive;
      logic [WORD_BITS-1:0] pin_output_enable;
      logic                 irq;
   } rsp_word_type;

endpackage

`default_nettype wire

/* sv/gpio_bank_chan_if.sv */
`default_nettype none

// Valid/ready channel carrying one word per handshake
interface gpio_bank_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

/* sv/gpio_bank_with_interrupt_detect.sv */
`default_nettype none

// Channel   Dir  Word           Meaning
// req_ch    in   req_word_type  pin sample tick, register read or register write
// rsp_ch    out  rsp_word_type  read data, pin drive, output enable, irq
//
// One request word is taken per clock while the response is not stalled.
// A word is registered in the input stage, then its register update and
// response are produced in one pass into the response register.
// Synchronous reset clears the bank registers and both stage valid flags.
// A stalled response holds the input stage; req_ch.ready follows
// rsp_ch.ready through the two stages.
module gpio_bank_with_interrupt_detect
   import gpio_bank_pkg::*;
#(
   parameter int unsigned PIN_COUNT = 32
) (
   input wire logic          clock,
   input wire logic          reset,
   gpio_bank_chan_if.sink    req_ch,
   gpio_bank_chan_if.source  rsp_ch
);
   typedef logic [PIN_COUNT-1:0] pins_type;

   // Input stage
   logic         s1_valid_ff;
   req_word_type s1_word_ff;

   // Response stage
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;

   // Bank registers
   pins_type out_value_ff,  out_value_in;
   pins_type out_enable_ff, out_enable_in;
   pins_type irq_enable_ff, irq_enable_in;
   pins_type edge_mode_ff,  edge_mode_in;
   pins_type polarity_ff,   polarity_in;
   pins_type status_ff,     status_in;
   pins_type cur_pins_ff,   cur_pins_in;

   logic     rsp_free;
   logic     s1_advance;
   pins_type levels;
   pins_type wdata;
   pins_type hit;
   pins_type rdata;

   // Handshake
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_advance   = s1_valid_ff && rsp_free;
   assign req_ch.ready = !s1_valid_ff || rsp_free;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word  = rsp_word_ff;

   assign levels = s1_word_ff.pin_levels[PIN_COUNT-1:0];
   assign wdata  = s1_word_ff.write_data[PIN_COUNT-1:0];

   gpio_bank_detect #(
      .PIN_COUNT (PIN_COUNT)
   ) u_detect (
      .prev_pins (cur_pins_ff),
      .new_pins  (levels),
      .edge_mode (edge_mode_ff),
      .polarity  (polarity_ff),
      .hit       (hit)
   );

   // Register update and read mux for the word in the input stage
   always_comb begin
      out_value_in  = out_value_ff;
      out_enable_in = out_enable_ff;
      irq_enable_in = irq_enable_ff;
      edge_mode_in  = edge_mode_ff;
      polarity_in   = polarity_ff;
      status_in     = status_ff;
      cur_pins_in   = cur_pins_ff;
      rdata         = '0;
      case (opcode_type'(s1_word_ff.opcode))
         OP_SAMPLE: begin
            status_in   = status_ff | hit;
            cur_pins_in = levels;
         end
         OP_READ: begin
            unique case (reg_select_type'(s1_word_ff.reg_select))
               REG_OUT:        rdata = out_value_ff;
               REG_IN:         rdata = cur_pins_ff;
               REG_STATUS:     rdata = status_ff;
               REG_CLEAR:      rdata = '0;
               REG_ENABLE:     rdata = irq_enable_ff;
               REG_EDGE:       rdata = edge_mode_ff;
               REG_POLARITY:   rdata = polarity_ff;
               REG_OUT_ENABLE: rdata = out_enable_ff;
               default:        rdata = '0;
            endcase
         end
         OP_WRITE: begin
            // input and status are read-only
            unique case (reg_select_type'(s1_word_ff.reg_select))
               REG_OUT:        out_value_in  = wdata;
               REG_CLEAR:      status_in     = status_ff & ~wdata;
               REG_ENABLE:     irq_enable_in = wdata;
               REG_EDGE:       edge_mode_in  = wdata;
               REG_POLARITY:   polarity_in   = wdata;
               REG_OUT_ENABLE: out_enable_in = wdata;
               default:        ;
            endcase
         end
         default: ;
      endcase

      rsp_word_in.read_data         = WORD_BITS'(rdata);
      rsp_word_in.pin_drive         = WORD_BITS'(out_value_in);
      rsp_word_in.pin_output_enable = WORD_BITS'(out_enable_in);
      rsp_word_in.irq               = |(status_in & irq_enable_in);
   end

   // Stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         s1_word_ff <= req_ch.word;
      end
      if (s1_advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Bank registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_value_ff  <= '0;
         out_enable_ff <= '0;
         irq_enable_ff <= '0;
         edge_mode_ff  <= '0;
         polarity_ff   <= '0;
         status_ff     <= '0;
         cur_pins_ff   <= '0;
      end else if (s1_advance) begin
         out_value_ff  <= out_value_in;
         out_enable_ff <= out_enable_in;
         irq_enable_ff <= irq_enable_in;
         edge_mode_ff  <= edge_mode_in;
         polarity_ff   <= polarity_in;
         status_ff     <= status_in;
         cur_pins_ff   <= cur_pins_in;
      end
   end
endmodule

`default_nettype wire

/* sv/gpio_bank_detect.sv */
`default_nettype none

// Per-pin interrupt detector for one sample tick
module gpio_bank_detect #(
   parameter int unsigned PIN_COUNT = 32
) (
   input  wire logic [PIN_COUNT-1:0] prev_pins,
   input  wire logic [PIN_COUNT-1:0] new_pins,
   input  wire logic [PIN_COUNT-1:0] edge_mode,
   input  wire logic [PIN_COUNT-1:0] polarity,
   output logic      [PIN_COUNT-1:0] hit
);
   logic [PIN_COUNT-1:0] rising;
   logic [PIN_COUNT-1:0] falling;
   logic [PIN_COUNT-1:0] edge_hit;
   logic [PIN_COUNT-1:0] level_hit;

   always_comb begin
      rising    = ~prev_pins & new_pins;
      falling   = prev_pins & ~new_pins;
      // polarity 1: rising edge / high level, polarity 0: falling / low
      edge_hit  = (polarity & rising) | (~polarity & falling);
      level_hit = ~(new_pins ^ polarity);
      hit       = (edge_mode & edge_hit) | (~edge_mode & level_hit);
   end
endmodule

`default_nettype wire
